// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the screen transform core.
// Clock is clk and reset is arst_n in every file that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PSRS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Check that one condition is followed by another in the next cycle.
`define PSRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PSRS_ASSERT(lbl, prop)
`define PSRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/psrs_pkg.sv =====
package psrs_pkg;

	// field and datapath widths
	localparam int COORD_W    = 16;
	localparam int ANGLE_W    = 9;
	localparam int DIFF_W     = 18;
	localparam int TRIG_W     = 16;
	localparam int PROD_W     = 34;
	localparam int ROT_W      = 35;
	localparam int GAIN_W     = 17;
	localparam int CMUL_W     = 33;
	localparam int SMUL_W     = 51;
	localparam int SUM_W      = 54;
	localparam int TRIG_SHIFT = 14;
	localparam int FRAC_SHIFT = 26;
	localparam int PIX_W      = SUM_W - FRAC_SHIFT;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// register indexes
	typedef logic [CFG_IDX_W-1:0] reg_index_t;
	localparam reg_index_t REG_OFFSET_X     = 3'd0;
	localparam reg_index_t REG_OFFSET_Y     = 3'd1;
	localparam reg_index_t REG_PIVOT_X      = 3'd2;
	localparam reg_index_t REG_PIVOT_Y      = 3'd3;
	localparam reg_index_t REG_ANGLE_DEG    = 3'd4;
	localparam reg_index_t REG_SCALE_KX     = 3'd5;
	localparam reg_index_t REG_SCALE_KY     = 3'd6;
	localparam reg_index_t REG_SCALE_CENTER = 3'd7;

	localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
	localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
	localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

	// offset point relative to the pivot
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} delta_t;

	// transform settings seen by the back end
	typedef struct packed {
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
		logic signed [TRIG_W-1:0]  sin_v;
		logic signed [TRIG_W-1:0]  cos_v;
		logic signed [COORD_W-1:0] kx;
		logic signed [COORD_W-1:0] ky;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} xform_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// round(16384 * sin(d degrees)) for d = 0..90
	localparam logic [14:0] QSINE [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16025, 15'd16082,
		15'd16135, 15'd16182, 15'd16224, 15'd16262, 15'd16294,
		15'd16322, 15'd16345, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// fold an angle of one turn or more back by one turn
	function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W-1:0] d);
		return (d >= DEG_360) ? d - DEG_360 : d;
	endfunction

	// sine in Q1.14 from the quarter-wave table
	function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [ANGLE_W-1:0] d);
		logic [ANGLE_W-1:0] a;
		logic [6:0]         idx;
		logic               neg;
		logic signed [TRIG_W-1:0] mag;
		a = wrap_deg(d);
		if (a <= DEG_90) begin
			idx = a[6:0];
			neg = 1'b0;
		end else if (a <= DEG_180) begin
			idx = 7'(DEG_180 - a);
			neg = 1'b0;
		end else if (a <= DEG_270) begin
			idx = 7'(a - DEG_180);
			neg = 1'b1;
		end else begin
			idx = 7'(DEG_360 - a);
			neg = 1'b1;
		end
		mag = $signed({1'b0, QSINE[idx]});
		return neg ? -mag : mag;
	endfunction

endpackage

// ===== rtl/core/psrs_front.sv =====
module psrs_front (
	input  logic                             start,
	output logic                             busy,
	input  logic signed [psrs_pkg::COORD_W-1:0] point_x,
	input  logic signed [psrs_pkg::COORD_W-1:0] point_y,
	input  logic signed [psrs_pkg::COORD_W-1:0] offset_x,
	input  logic signed [psrs_pkg::COORD_W-1:0] offset_y,
	input  logic signed [psrs_pkg::COORD_W-1:0] pivot_x,
	input  logic signed [psrs_pkg::COORD_W-1:0] pivot_y,
	input  psrs_pkg::qstat_t                 qstat,
	output logic                             push,
	output psrs_pkg::delta_t                 delta
);
	import psrs_pkg::*;

	// hold requests off while the queue has no room
	assign busy = qstat.full;
	assign push = start && !qstat.full;

	// shift the point and take it relative to the pivot
	assign delta.dx = DIFF_W'(point_x) + DIFF_W'(offset_x) - DIFF_W'(pivot_x);
	assign delta.dy = DIFF_W'(point_y) + DIFF_W'(offset_y) - DIFF_W'(pivot_y);

endmodule

// ===== rtl/core/psrs_queue.sv =====
module psrs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psrs_pkg::delta_t wr_data,
	input  logic             pop,
	output psrs_pkg::delta_t rd_data,
	output psrs_pkg::qstat_t qstat
);
	import psrs_pkg::*;

	delta_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_pop      = pop && !qstat.empty;
	assign rd_data     = mem_q[rd_ptr_q];

	// store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/psrs_back.sv =====
module psrs_back #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  psrs_pkg::delta_t                     delta,
	input  psrs_pkg::xform_t                     xf,
	output logic                                 done,
	output logic signed [psrs_pkg::COORD_W-1:0]  screen_x,
	output logic signed [psrs_pkg::COORD_W-1:0]  screen_y,
	output logic                                 saturated
);
	import psrs_pkg::*;

	// screen center plus half a pixel for rounding, in Q.26
	localparam logic signed [SUM_W-1:0] BIAS_X = SUM_W'(
		(longint'(SCREEN_WIDTH / 2) <<< FRAC_SHIFT) + (longint'(1) <<< (FRAC_SHIFT - 1)));
	localparam logic signed [SUM_W-1:0] BIAS_Y = SUM_W'(
		(longint'(SCREEN_HEIGHT / 2) <<< FRAC_SHIFT) + (longint'(1) <<< (FRAC_SHIFT - 1)));
	localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(32767);
	localparam logic signed [PIX_W-1:0] PIX_MIN = -PIX_W'(32768);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] dxc, dys, dyc, dxs;
	logic signed [PROD_W-1:0] dxc_s1, dys_s1, dyc_s1, dxs_s1;
	logic signed [ROT_W-1:0]  xr, yr, xr_s2, yr_s2;
	logic signed [GAIN_W-1:0] gx, gy;
	logic signed [SMUL_W-1:0] xm, ym, xm_s3, ym_s3;
	logic signed [CMUL_W-1:0] xcm, ycm, xcm_s3, ycm_s3;
	logic signed [SUM_W-1:0]  sx, sy, sx_s4, sy_s4;
	logic signed [PIX_W-1:0]  pix_x, pix_y;
	logic sat_x, sat_y;

	// rotation products
	assign dxc = PROD_W'(delta.dx) * PROD_W'(xf.cos_v);
	assign dys = PROD_W'(delta.dy) * PROD_W'(xf.sin_v);
	assign dyc = PROD_W'(delta.dy) * PROD_W'(xf.cos_v);
	assign dxs = PROD_W'(delta.dx) * PROD_W'(xf.sin_v);

	// rotated point in Q.14
	assign xr = (ROT_W'(xf.pivot_x) <<< TRIG_SHIFT) + ROT_W'(dxc_s1) + ROT_W'(dys_s1);
	assign yr = (ROT_W'(xf.pivot_y) <<< TRIG_SHIFT) + ROT_W'(dyc_s1) - ROT_W'(dxs_s1);

	// scale products and center terms
	assign gx  = GAIN_W'(256) - GAIN_W'(xf.kx);
	assign gy  = GAIN_W'(256) - GAIN_W'(xf.ky);
	assign xm  = SMUL_W'(xr_s2) * SMUL_W'(xf.kx);
	assign ym  = SMUL_W'(yr_s2) * SMUL_W'(xf.ky);
	assign xcm = CMUL_W'(gx) * CMUL_W'(xf.cx);
	assign ycm = CMUL_W'(gy) * CMUL_W'(xf.cy);

	// screen mapping in Q.26, y axis flipped
	assign sx = BIAS_X + SUM_W'(xm_s3) + (SUM_W'(xcm_s3) <<< TRIG_SHIFT);
	assign sy = BIAS_Y - SUM_W'(ym_s3) - (SUM_W'(ycm_s3) <<< TRIG_SHIFT);

	// drop the fraction (floor) and clamp
	assign pix_x = PIX_W'(sx_s4 >>> FRAC_SHIFT);
	assign pix_y = PIX_W'(sy_s4 >>> FRAC_SHIFT);
	assign sat_x = (pix_x > PIX_MAX) || (pix_x < PIX_MIN);
	assign sat_y = (pix_y > PIX_MAX) || (pix_y < PIX_MIN);

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		dxc_s1 <= dxc;
		dys_s1 <= dys;
		dyc_s1 <= dyc;
		dxs_s1 <= dxs;
		xr_s2  <= xr;
		yr_s2  <= yr;
		xm_s3  <= xm;
		ym_s3  <= ym;
		xcm_s3 <= xcm;
		ycm_s3 <= ycm;
		sx_s4  <= sx;
		sy_s4  <= sy;
		if (pix_x > PIX_MAX) begin
			screen_x <= COORD_W'(PIX_MAX);
		end else if (pix_x < PIX_MIN) begin
			screen_x <= COORD_W'(PIX_MIN);
		end else begin
			screen_x <= COORD_W'(pix_x);
		end
		if (pix_y > PIX_MAX) begin
			screen_y <= COORD_W'(PIX_MAX);
		end else if (pix_y < PIX_MIN) begin
			screen_y <= COORD_W'(PIX_MIN);
		end else begin
			screen_y <= COORD_W'(pix_y);
		end
		saturated <= sat_x || sat_y;
	end

endmodule

// ===== rtl/core/point_shift_rotate_scale_to_screen.sv =====
// A taken request is written into the queue and then passes through the five
// back-end stages; done is registered together with the result.
// Throughput: one point per cycle; the five-stage multiply/add back end takes
// one entry of the two-deep queue each cycle, so busy stays low in steady use.
// The receiver cannot stall: done marks each result for exactly one cycle.
// Reset (arst_n low, asynchronous) empties the queue and pipeline and sets the
// registers to offset, pivot, angle and center 0 and both scale factors 1.0.
`include "assert_macros.svh"
module point_shift_rotate_scale_to_screen #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [psrs_pkg::COORD_W-1:0]    point_x,
	input  logic signed [psrs_pkg::COORD_W-1:0]    point_y,
	output logic                                   done,
	output logic signed [psrs_pkg::COORD_W-1:0]    screen_x,
	output logic signed [psrs_pkg::COORD_W-1:0]    screen_y,
	output logic                                   saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [psrs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [psrs_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import psrs_pkg::*;

	logic signed [COORD_W-1:0] offset_x_q, offset_y_q, pivot_x_q, pivot_y_q;
	logic signed [COORD_W-1:0] scale_kx_q, scale_ky_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic [CFG_DATA_W-1:0]     center_q;
	logic signed [TRIG_W-1:0]  sin_q, cos_q;
	logic [ANGLE_W-1:0]        angle_w;
	logic                      push;
	delta_t                    push_data;
	delta_t                    head;
	qstat_t                    qstat;
	xform_t                    xf;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			pivot_x_q  <= '0;
			pivot_y_q  <= '0;
			angle_q    <= '0;
			scale_kx_q <= COORD_W'(256);
			scale_ky_q <= COORD_W'(256);
			center_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET_X:     offset_x_q <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Y:     offset_y_q <= cfg_data[COORD_W-1:0];
				REG_PIVOT_X:      pivot_x_q  <= cfg_data[COORD_W-1:0];
				REG_PIVOT_Y:      pivot_y_q  <= cfg_data[COORD_W-1:0];
				REG_ANGLE_DEG:    angle_q    <= cfg_data[ANGLE_W-1:0];
				REG_SCALE_KX:     scale_kx_q <= cfg_data[COORD_W-1:0];
				REG_SCALE_KY:     scale_ky_q <= cfg_data[COORD_W-1:0];
				REG_SCALE_CENTER: center_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// look up sine and cosine of the current angle
	assign angle_w = wrap_deg(angle_q);
	always_ff @(posedge clk) begin
		sin_q <= sine_deg(angle_w);
		cos_q <= sine_deg(angle_w + DEG_90);
	end

	assign xf.pivot_x = pivot_x_q;
	assign xf.pivot_y = pivot_y_q;
	assign xf.sin_v   = sin_q;
	assign xf.cos_v   = cos_q;
	assign xf.kx      = scale_kx_q;
	assign xf.ky      = scale_ky_q;
	assign xf.cx      = center_q[COORD_W-1:0];
	assign xf.cy      = center_q[CFG_DATA_W-1:COORD_W];

	psrs_front u_front (
		.start    (start),
		.busy     (busy),
		.point_x  (point_x),
		.point_y  (point_y),
		.offset_x (offset_x_q),
		.offset_y (offset_y_q),
		.pivot_x  (pivot_x_q),
		.pivot_y  (pivot_y_q),
		.qstat    (qstat),
		.push     (push),
		.delta    (push_data)
	);

	psrs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (!qstat.empty),
		.rd_data (head),
		.qstat   (qstat)
	);

	psrs_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!qstat.empty),
		.delta     (head),
		.xf        (xf),
		.done      (done),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.saturated (saturated)
	);

	// every accepted request yields one result, and every result stems from an accepted request
	`PSRS_ASSERT(a_req_to_done, (start && !busy) |-> ##6 done)
	`PSRS_ASSERT(a_done_from_req, done |-> $past(start && !busy, 6))
	// a flagged result sits at a rail
	`PSRS_ASSERT(a_sat_at_rail, (done && saturated) |-> (screen_x == 16'sh7fff ||
		screen_x == 16'sh8000 || screen_y == 16'sh7fff || screen_y == 16'sh8000))
	// the back end drains the queue, so a request never meets a full queue twice
	`PSRS_ASSERT_NEXT(a_busy_clears, busy, !busy)

endmodule

// ===== tb/sv/tb_point_shift_rotate_scale_to_screen.sv =====
`timescale 1ns / 1ps

// Expected screen pixels for accepted points, with a mirror of the transform registers
class pixel_scoreboard;
	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic               sat;
	} pixel_t;

	logic signed [15:0] off_x, off_y, piv_x, piv_y, kx, ky;
	logic [8:0]         angle;
	logic [31:0]        center;
	int                 sine_q14 [91];
	longint             half_w, half_h;
	pixel_t             pixel_q [$];
	int                 mismatches, checked, clamped;

	function new(int width, int height);
		half_w = longint'(width / 2);
		half_h = longint'(height / 2);
		off_x = '0;
		off_y = '0;
		piv_x = '0;
		piv_y = '0;
		angle = '0;
		kx = 16'sd256;
		ky = 16'sd256;
		center = '0;
		mismatches = 0;
		checked = 0;
		clamped = 0;
		// round(16384 * sin(d)) for d = 0..90 degrees
		sine_q14 = '{
			    0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
			 2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
			 5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
			 8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
			10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
			12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
			14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
			15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16025, 16082,
			16135, 16182, 16224, 16262, 16294, 16322, 16345, 16362, 16374, 16382,
			16384
		};
	endfunction

	// Mirror one register write; an index outside the map changes nothing
	function void set_reg(psrs_pkg::reg_index_t idx, logic [31:0] data);
		case (idx)
			psrs_pkg::REG_OFFSET_X:     off_x = data[15:0];
			psrs_pkg::REG_OFFSET_Y:     off_y = data[15:0];
			psrs_pkg::REG_PIVOT_X:      piv_x = data[15:0];
			psrs_pkg::REG_PIVOT_Y:      piv_y = data[15:0];
			psrs_pkg::REG_ANGLE_DEG:    angle = data[8:0];
			psrs_pkg::REG_SCALE_KX:     kx = data[15:0];
			psrs_pkg::REG_SCALE_KY:     ky = data[15:0];
			psrs_pkg::REG_SCALE_CENTER: center = data;
			default: ;
		endcase
	endfunction

	// Sine in Q1.14 of a whole-degree angle 0..359
	function longint sine_of(int d);
		if (d <= 90)
			return longint'(sine_q14[d]);
		if (d <= 180)
			return longint'(sine_q14[180 - d]);
		if (d <= 270)
			return -longint'(sine_q14[d - 180]);
		return -longint'(sine_q14[360 - d]);
	endfunction

	// Round a Q.26 value to a pixel, ties upward, and clamp to 16 bits
	function longint round_clamp(longint q26, inout bit sat);
		longint p;
		p = (q26 + (longint'(1) <<< 25)) >>> 26;
		if (p > 32767) begin
			sat = 1'b1;
			return 32767;
		end
		if (p < -32768) begin
			sat = 1'b1;
			return -32768;
		end
		return p;
	endfunction

	// Work out the pixel of an accepted point and queue it
	function void note_point(logic signed [15:0] x, logic signed [15:0] y);
		int     a;
		longint s, c, x1, y1, px, py, dx, dy, xr, yr, gx, gy, cx, cy, xs, ys, sxp, syp;
		bit     sat;
		pixel_t want;
		sat = 1'b0;
		a = int'(angle);
		if (a >= 360)
			a -= 360;
		s = sine_of(a);
		c = sine_of((a + 90) % 360);
		// shift, then rotate clockwise about the pivot
		x1 = longint'(x) + longint'(off_x);
		y1 = longint'(y) + longint'(off_y);
		px = longint'(piv_x);
		py = longint'(piv_y);
		dx = x1 - px;
		dy = y1 - py;
		xr = px * 16384 + dx * c + dy * s;
		yr = py * 16384 + dy * c - dx * s;
		// scale about the center
		gx = longint'(kx);
		gy = longint'(ky);
		cx = longint'($signed(center[15:0]));
		cy = longint'($signed(center[31:16]));
		xs = xr * gx + (256 - gx) * cx * 16384;
		ys = yr * gy + (256 - gy) * cy * 16384;
		// map to the screen, y downward
		sxp = round_clamp(xs + (half_w <<< 26), sat);
		syp = round_clamp(-ys + (half_h <<< 26), sat);
		want.sx = sxp[15:0];
		want.sy = syp[15:0];
		want.sat = sat;
		pixel_q.push_back(want);
	endfunction

	function int pending();
		return pixel_q.size();
	endfunction

	task report(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Compare a pixel from the block with the oldest expectation
	task check_pixel(logic signed [15:0] sx, logic signed [15:0] sy, logic sat);
		pixel_t want;
		if (pixel_q.size() == 0) begin
			report($sformatf("unexpected pixel (%0d, %0d) sat %b", sx, sy, sat));
		end else begin
			want = pixel_q.pop_front();
			checked++;
			if (want.sat)
				clamped++;
			if (sx !== want.sx)
				report($sformatf("screen_x %0d, want %0d", sx, want.sx));
			if (sy !== want.sy)
				report($sformatf("screen_y %0d, want %0d", sy, want.sy));
			if (sat !== want.sat)
				report($sformatf("saturated %b, want %b", sat, want.sat));
		end
	endtask
endclass

module tb_point_shift_rotate_scale_to_screen;
	import psrs_pkg::*;

	localparam int SCREEN_W      = 640;
	localparam int SCREEN_H      = 480;
	localparam int HALF_PERIOD   = 5;
	localparam int PIPE_LAT      = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 16;

	typedef struct {
		logic [15:0] ox, oy, pvx, pvy;
		logic [8:0]  ang;
		logic [15:0] kx, ky;
		logic [31:0] ctr;
	} xform_cfg_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [COORD_W-1:0]   point_x = '0;
	logic signed [COORD_W-1:0]   point_y = '0;
	logic                        done;
	logic signed [COORD_W-1:0]   screen_x;
	logic signed [COORD_W-1:0]   screen_y;
	logic                        saturated;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	pixel_scoreboard sb = new(SCREEN_W, SCREEN_H);
	bit              gaps_on = 1'b1;
	int              stall_cycles = 0;
	int              settings_done = 0;

	point_shift_rotate_scale_to_screen #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.point_x  (point_x),
		.point_y  (point_y),
		.done     (done),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Check every strobed pixel
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel(screen_x, screen_y, saturated);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no request or pixel for %0d cycles", STALL_LIMIT);
				$display("point_shift_rotate_scale_to_screen regression: fail");
				$finish;
			end
		end
	end

	// Offer one point until taken; idle randomly first
	task automatic send_point(int x, int y);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 34) begin
				@(negedge clk);
				start <= 1'b0;
				point_x <= 16'($urandom());
				point_y <= 16'($urandom());
			end
		end
		@(negedge clk);
		start <= 1'b1;
		point_x <= 16'(x);
		point_y <= 16'(y);
		do @(posedge clk); while (busy);
		sb.note_point(16'(x), 16'(y));
	endtask

	// Hold one register write request until taken
	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 34) begin
				@(negedge clk);
				cfg_valid <= 1'b0;
			end
		end
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// Fill unused upper data bits with noise
	function automatic logic [31:0] pad(logic [31:0] v, int w);
		logic [31:0] r, mask;
		r = $urandom();
		mask = (32'h1 << w) - 32'h1;
		return (r & ~mask) | (v & mask);
	endfunction

	// Let all pixels drain, then wait out the pipeline
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// Program every register while the block is idle
	task automatic program_xform(xform_cfg_t c);
		drain();
		write_reg(REG_OFFSET_X, pad(c.ox, 16));
		write_reg(REG_OFFSET_Y, pad(c.oy, 16));
		write_reg(REG_PIVOT_X, pad(c.pvx, 16));
		write_reg(REG_PIVOT_Y, pad(c.pvy, 16));
		write_reg(REG_ANGLE_DEG, pad(c.ang, 9));
		write_reg(REG_SCALE_KX, pad(c.kx, 16));
		write_reg(REG_SCALE_KY, pad(c.ky, 16));
		write_reg(REG_SCALE_CENTER, c.ctr);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	function automatic xform_cfg_t make_cfg(int ox, int oy, int pvx, int pvy, int ang,
			int kx, int ky, int cx, int cy);
		xform_cfg_t c;
		c.ox = 16'(ox);
		c.oy = 16'(oy);
		c.pvx = 16'(pvx);
		c.pvy = 16'(pvy);
		c.ang = 9'(ang);
		c.kx = 16'(kx);
		c.ky = 16'(ky);
		c.ctr = {16'(cy), 16'(cx)};
		return c;
	endfunction

	// Coordinates: mostly near the screen, some extremes and full range
	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2, 3: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	function automatic int rand_scale();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 256;
			3: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 1023)) - 512;
		endcase
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(0, 7))
			0: return $urandom_range(360, 511);
			1: return 90 * $urandom_range(0, 3);
			default: return $urandom_range(0, 359);
		endcase
	endfunction

	function automatic xform_cfg_t rand_cfg();
		return make_cfg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_angle(), rand_scale(), rand_scale(), rand_coord(), rand_coord());
	endfunction

	initial begin
		int n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: identity; half-pixel ties and coordinate extremes
		send_point(0, 0);
		send_point(8, 8);
		send_point(-8, -8);
		send_point(24, -24);
		send_point(32767, 32767);
		send_point(-32768, -32768);
		send_point(32767, -32768);
		send_point(-32768, 32767);
		send_point(16'h5555, 16'hAAAA);

		// Quarter turn about an offset pivot
		program_xform(make_cfg(0, 0, 160, -160, 90, 256, 256, 0, 0));
		send_point(0, 0);
		send_point(1600, 0);
		send_point(-32768, 32767);

		// Angle past a full turn, extreme offsets
		program_xform(make_cfg(32767, -32768, 0, 0, 400, 256, 256, 0, 0));
		send_point(32767, 32767);
		send_point(-32768, -32768);
		send_point(100, -100);

		// Extreme scale factors and center: clamp both ways
		program_xform(make_cfg(0, 0, 0, 0, 270, 32767, -32768, -32768, 32767));
		send_point(0, 0);
		send_point(32767, -32768);
		send_point(-5, 7);

		// Zero and negative scale, extreme pivot, last degree
		program_xform(make_cfg(-1, 1, -32768, 32767, 359, 0, -256, 1234, -4321));
		send_point(1, 1);
		send_point(-32768, 32767);
		send_point(32767, 32767);

		// Half turn with every register at an extreme
		program_xform(make_cfg(-32768, 32767, 32767, -32768, 180, -32768, 32767,
			32767, -32768));
		send_point(-32768, -32768);
		send_point(0, 0);
		send_point(32767, 32767);

		// Random settings, each followed by a burst of random points
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			gaps_on = !(p >= 6 && p <= 8);
			program_xform(rand_cfg());
			n = $urandom_range(40, 64);
			repeat (n) send_point(rand_coord(), rand_coord());
		end
		gaps_on = 1'b1;

		// Wait for the last pixels and any stray strobe
		drain();
		repeat (PIPE_LAT + 5) @(posedge clk);

		$display("checked %0d pixels over %0d register settings plus reset defaults;",
			sb.checked, settings_done);
		$display("%0d pixels clamped, %0d mismatches", sb.clamped, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("point_shift_rotate_scale_to_screen regression: pass");
		end else begin
			$display("point_shift_rotate_scale_to_screen regression: fail");
		end
		$finish;
	end
endmodule
